@@ hw/rtl/pib_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_pkg: shared types and constants of the point-in-box classifier
// function codes, status codes, fixed field widths and the cell command
// ----------------------------------------------------------------------------
package pib_pkg;

    localparam int MAX_BOXES_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;

    localparam int FUNC_W        = 2;
    localparam int SIZE_W        = 16;
    localparam int TOL_W         = 15;
    localparam int STATUS_W      = 2;
    localparam int QNUM_W        = 16;
    localparam int BOX_INDEX_W   = 5;
    localparam int MATCH_COUNT_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ATTACHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AMBIG    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // per-cell command from the controller
    typedef struct packed {
        logic             load;
        logic             occupied;
        logic [TOL_W-1:0] tolerance;
    } cell_cmd_t;

endpackage

@@ hw/rtl/pib_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_if: channel interfaces of the point-in-box classifier
// request, result and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface pib_in_if #(
    parameter int COORD_BITS = pib_pkg::COORD_BITS_DEF
);
    import pib_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [FUNC_W-1:0]            func;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [SIZE_W-1:0]            size_x;
    logic [SIZE_W-1:0]            size_y;

    modport source (output valid, func, center_x, center_y, size_x, size_y, input ready);
    modport sink   (input valid, func, center_x, center_y, size_x, size_y, output ready);
endinterface

interface pib_out_if;
    import pib_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [QNUM_W-1:0]        query_number;
    logic [BOX_INDEX_W-1:0]   box_index;
    logic [MATCH_COUNT_W-1:0] match_count;
    logic                     last;

    modport source (output valid, status, query_number, box_index, match_count, last,
                    input ready);
    modport sink   (input valid, status, query_number, box_index, match_count, last,
                    output ready);
endinterface

interface pib_cfg_if;
    import pib_pkg::*;

    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/pib_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_cell: one box slot of the classifier chain
// holds one box, tests the passing query wave and hands it to the next cell
// ----------------------------------------------------------------------------
module pib_cell #(
    parameter int MAX_BOXES  = pib_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = pib_pkg::COORD_BITS_DEF,
    parameter int INDEX      = 0,
    localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    localparam int CNT_W     = $clog2(MAX_BOXES + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pib_pkg::cell_cmd_t           cmd,
    input  logic signed [COORD_BITS-1:0] ld_cx,
    input  logic signed [COORD_BITS-1:0] ld_cy,
    input  logic [pib_pkg::SIZE_W-1:0]   ld_w,
    input  logic [pib_pkg::SIZE_W-1:0]   ld_h,
    input  logic                         wi_valid,
    input  logic signed [COORD_BITS-1:0] wi_px,
    input  logic signed [COORD_BITS-1:0] wi_py,
    input  logic [CNT_W-1:0]             wi_count,
    input  logic [IDX_W-1:0]             wi_first,
    output logic                         wo_valid,
    output logic signed [COORD_BITS-1:0] wo_px,
    output logic signed [COORD_BITS-1:0] wo_py,
    output logic [CNT_W-1:0]             wo_count,
    output logic [IDX_W-1:0]             wo_first,
    output logic                         hit
);
    import pib_pkg::*;

    // 2*(p-c) needs COORD_BITS+2 signed, size+2*tol needs 17 unsigned
    localparam int D_W   = COORD_BITS + 2;
    localparam int CMP_W = ((D_W > 18) ? D_W : 18) + 1;

    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [SIZE_W-1:0]            w_reg, h_reg;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [IDX_W-1:0]             first_reg;
    logic                         hit_reg;

    logic signed [CMP_W-1:0] dx, dy, bx, by;
    logic                    contained;

    assign dx = (CMP_W'(wi_px) - CMP_W'(cx_reg)) <<< 1;
    assign dy = (CMP_W'(wi_py) - CMP_W'(cy_reg)) <<< 1;
    assign bx = $signed(CMP_W'(w_reg)) + $signed(CMP_W'(cmd.tolerance) << 1);
    assign by = $signed(CMP_W'(h_reg)) + $signed(CMP_W'(cmd.tolerance) << 1);

    assign contained = cmd.occupied && (dx >= -bx) && (dx <= bx) &&
                       (dy >= -by) && (dy <= by);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= ld_cx;
            cy_reg <= ld_cy;
            w_reg  <= ld_w;
            h_reg  <= ld_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= wi_valid;
    end

    always_ff @(posedge clk)
    begin
        if (wi_valid)
        begin
            px_reg    <= wi_px;
            py_reg    <= wi_py;
            hit_reg   <= contained;
            count_reg <= wi_count + CNT_W'(contained);
            // first containing box seen along the chain
            first_reg <= (contained && (wi_count == '0)) ? IDX_W'(INDEX) : wi_first;
        end
    end

    assign wo_valid = valid_reg;
    assign wo_px    = px_reg;
    assign wo_py    = py_reg;
    assign wo_count = count_reg;
    assign wo_first = first_reg;
    assign hit      = hit_reg;

endmodule

@@ hw/rtl/point_in_box_attach_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_box_attach_classifier_top: point-in-box attach classifier
// box table held in a chain of cells, query wave through the chain
// ----------------------------------------------------------------------------
// usage
//   req: one transaction per command: clear (func 0), load box (func 1) or
//     query point (func 2); unused codes are dropped
//   cfg: one write sets the tolerance; write only while the block is idle
//   rsp: result transactions; last marks the end of each command's run
// timing
//   clear and load stay in the idle state; a load into a full table gives one
//   table-full result, loaded into the result register from S_RESP
//   a query walks the chain one cell per cycle; the controller waits in
//   S_SWEEP until the wave leaves the last cell, and req is ready again
//   once a single result is loaded from S_RESP
//   an ambiguous query scans the hit flags one cell a cycle, held while
//   rsp stalls, up to the highest containing index, before req is ready again
// reset
//   table empty, query counter and tolerance zero, no result pending
// stalls
//   a stalled rsp holds the result register; the block takes no new
//   request until the last result of the current command sits in the
//   result register
// ----------------------------------------------------------------------------
module point_in_box_attach_classifier_top #(
    parameter int MAX_BOXES  = pib_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = pib_pkg::COORD_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    pib_in_if.sink    req,
    pib_cfg_if.sink   cfg,
    pib_out_if.source rsp
);
    import pib_pkg::*;

    localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    // controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] box_count_reg, box_count_next;
    logic [QNUM_W-1:0] qc_reg, qc_next;
    logic [TOL_W-1:0] tol_reg;

    // per-command result context
    logic [QNUM_W-1:0]   qn_reg, qn_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [STATUS_W-1:0] pend_st_reg, pend_st_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]    emit_cnt_reg, emit_cnt_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_load;
    logic [STATUS_W-1:0]      o_status_reg, o_status_next;
    logic [QNUM_W-1:0]        o_qnum_reg, o_qnum_next;
    logic [BOX_INDEX_W-1:0]   o_index_reg, o_index_next;
    logic [MATCH_COUNT_W-1:0] o_count_reg, o_count_next;
    logic                     o_last_reg, o_last_next;

    logic accept, load_ok, out_free, scan_last;

    // query wave through the chain, stage 0 fed from the request channel
    logic [MAX_BOXES:0]           wv;
    logic signed [COORD_BITS-1:0] wpx [MAX_BOXES+1];
    logic signed [COORD_BITS-1:0] wpy [MAX_BOXES+1];
    logic [CNT_W-1:0]             wcnt [MAX_BOXES+1];
    logic [IDX_W-1:0]             wfirst [MAX_BOXES+1];
    logic [MAX_BOXES-1:0]         hit_vec;
    cell_cmd_t                    cmd [MAX_BOXES];

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign load_ok   = accept && (req.func == FUNC_LOAD) &&
                       (box_count_reg != CNT_W'(MAX_BOXES));
    assign out_free  = !out_valid_reg || rsp.ready;

    assign wv[0]     = accept && (req.func == FUNC_QUERY);
    assign wpx[0]    = req.center_x;
    assign wpy[0]    = req.center_y;
    assign wcnt[0]   = '0;
    assign wfirst[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++)
        begin : g_cell
            // a box is written at the slot the fill count points to
            assign cmd[gi].load      = load_ok && (box_count_reg == CNT_W'(gi));
            assign cmd[gi].occupied  = (CNT_W'(gi) < box_count_reg);
            assign cmd[gi].tolerance = tol_reg;

            pib_cell #(
                .MAX_BOXES  (MAX_BOXES),
                .COORD_BITS (COORD_BITS),
                .INDEX      (gi)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd[gi]),
                .ld_cx    (req.center_x),
                .ld_cy    (req.center_y),
                .ld_w     (req.size_x),
                .ld_h     (req.size_y),
                .wi_valid (wv[gi]),
                .wi_px    (wpx[gi]),
                .wi_py    (wpy[gi]),
                .wi_count (wcnt[gi]),
                .wi_first (wfirst[gi]),
                .wo_valid (wv[gi+1]),
                .wo_px    (wpx[gi+1]),
                .wo_py    (wpy[gi+1]),
                .wo_count (wcnt[gi+1]),
                .wo_first (wfirst[gi+1]),
                .hit      (hit_vec[gi])
            );
        end
    endgenerate

    // final hit of an ambiguous run
    assign scan_last = (emit_cnt_reg + CNT_W'(1)) == total_reg;

    always_comb
    begin
        state_next     = state_reg;
        box_count_next = box_count_reg;
        qc_next        = qc_reg;
        qn_next        = qn_reg;
        total_next     = total_reg;
        pend_idx_next  = pend_idx_reg;
        pend_st_next   = pend_st_reg;
        scan_idx_next  = scan_idx_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_load       = 1'b0;
        o_status_next  = o_status_reg;
        o_qnum_next    = o_qnum_reg;
        o_index_next   = o_index_reg;
        o_count_next   = o_count_reg;
        o_last_next    = o_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_CLEAR:
                        begin
                            box_count_next = '0;
                            qc_next        = '0;
                        end
                        FUNC_LOAD:
                        begin
                            if (load_ok)
                                box_count_next = box_count_reg + CNT_W'(1);
                            else
                            begin
                                // table full, box dropped
                                pend_st_next  = ST_FULL;
                                pend_idx_next = '0;
                                total_next    = '0;
                                qn_next       = '0;
                                state_next    = S_RESP;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            qn_next    = qc_reg;
                            qc_next    = qc_reg + QNUM_W'(1);
                            state_next = S_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (wv[MAX_BOXES])
                begin
                    total_next = wcnt[MAX_BOXES];
                    if (wcnt[MAX_BOXES] == '0)
                    begin
                        pend_st_next  = ST_NONE;
                        pend_idx_next = '0;
                        state_next    = S_RESP;
                    end
                    else if (wcnt[MAX_BOXES] == CNT_W'(1))
                    begin
                        pend_st_next  = ST_ATTACHED;
                        pend_idx_next = wfirst[MAX_BOXES];
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        emit_cnt_next = '0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    o_status_next = pend_st_reg;
                    o_qnum_next   = qn_reg;
                    o_index_next  = BOX_INDEX_W'(pend_idx_reg);
                    o_count_next  = MATCH_COUNT_W'(total_reg);
                    o_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // one cell per cycle, held while the result register is busy
                if (out_free)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (hit_vec[scan_idx_reg])
                    begin
                        out_load      = 1'b1;
                        o_status_next = ST_AMBIG;
                        o_qnum_next   = qn_reg;
                        o_index_next  = BOX_INDEX_W'(scan_idx_reg);
                        o_count_next  = MATCH_COUNT_W'(total_reg);
                        o_last_next   = scan_last;
                        emit_cnt_next = emit_cnt_reg + CNT_W'(1);
                        if (scan_last)
                            state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            qc_reg        <= '0;
            tol_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            emit_cnt_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            qc_reg        <= qc_next;
            out_valid_reg <= out_valid_next;
            scan_idx_reg  <= scan_idx_next;
            emit_cnt_reg  <= emit_cnt_next;
            total_reg     <= total_next;
            if (cfg.valid && cfg.ready)
                tol_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg       <= qn_next;
        pend_idx_reg <= pend_idx_next;
        pend_st_reg  <= pend_st_next;
        o_status_reg <= o_status_next;
        o_qnum_reg   <= o_qnum_next;
        o_index_reg  <= o_index_next;
        o_count_reg  <= o_count_next;
        o_last_reg   <= o_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = o_status_reg;
    assign rsp.query_number = o_qnum_reg;
    assign rsp.box_index    = o_index_reg;
    assign rsp.match_count  = o_count_reg;
    assign rsp.last         = o_last_reg;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        box_count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table depth");

    // the query wave leaves the chain only while the controller waits for it
    a_wave_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wv[MAX_BOXES] |-> (state_reg == S_SWEEP))
        else $error("query wave left the chain outside the sweep");

    // an ambiguous run never emits more results than containing boxes
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (emit_cnt_reg < total_reg))
        else $error("ambiguous run overran its match count");

    // a query start always leaves the idle state for the sweep
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        wv[0] |=> (state_reg == S_SWEEP))
        else $error("query accepted without a sweep");

endmodule

@@ bench/pib_attach_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pib_attach_checker: result predictor and comparator
// watches the request, configuration and result channels, keeps its own
// box table, tolerance and query counter, and checks every result
// transaction against the oldest expected one
// ----------------------------------------------------------------------------
module pib_attach_checker #(
    parameter int MAX_BOXES = pib_pkg::MAX_BOXES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pib_in_if    req,
    pib_cfg_if   cfg,
    pib_out_if   rsp,
    output int   fail_count,
    output int   results_due
);
    import pib_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [QNUM_W-1:0]        query_number;
        logic [BOX_INDEX_W-1:0]   box_index;
        logic [MATCH_COUNT_W-1:0] match_count;
        logic                     last;
    } attach_result_t;

    logic signed [COORD_BITS_DEF-1:0] box_cx [MAX_BOXES];
    logic signed [COORD_BITS_DEF-1:0] box_cy [MAX_BOXES];
    logic [SIZE_W-1:0]                box_w  [MAX_BOXES];
    logic [SIZE_W-1:0]                box_h  [MAX_BOXES];
    int                               boxes_held;
    logic [QNUM_W-1:0]                query_count;
    logic [TOL_W-1:0]                 tolerance;
    attach_result_t                   expected_q [$];
    int                               mismatches;

    function automatic attach_result_t make_result(
        input logic [STATUS_W-1:0]      status,
        input logic [QNUM_W-1:0]        qnum,
        input logic [BOX_INDEX_W-1:0]   index,
        input logic [MATCH_COUNT_W-1:0] count,
        input logic                     last
    );
        attach_result_t r;
        r.status       = status;
        r.query_number = qnum;
        r.box_index    = index;
        r.match_count  = count;
        r.last         = last;
        return r;
    endfunction

    // append one expected result at the tail
    function automatic void expect_result(input attach_result_t r);
        expected_q = {expected_q, r};
    endfunction

    // exact test: |2*(p-c)| <= span + 2*margin
    function automatic bit axis_hit(input longint p, input longint c, input longint span,
                                    input longint margin);
        longint d;
        longint bound;
        d     = 2 * (p - c);
        bound = span + 2 * margin;
        return (d >= -bound) && (d <= bound);
    endfunction

    function automatic void classify_command(
        input logic [FUNC_W-1:0]                func,
        input logic signed [COORD_BITS_DEF-1:0] px,
        input logic signed [COORD_BITS_DEF-1:0] py,
        input logic [SIZE_W-1:0]                sx,
        input logic [SIZE_W-1:0]                sy
    );
        int                hits [$];
        logic [QNUM_W-1:0] qnum;
        case (func)
            FUNC_CLEAR:
            begin
                boxes_held  = 0;
                query_count = '0;
            end
            FUNC_LOAD:
            begin
                if (boxes_held >= MAX_BOXES)
                begin
                    expect_result(make_result(ST_FULL, '0, '0, '0, 1'b1));
                end
                else
                begin
                    box_cx[boxes_held] = px;
                    box_cy[boxes_held] = py;
                    box_w[boxes_held]  = sx;
                    box_h[boxes_held]  = sy;
                    boxes_held++;
                end
            end
            FUNC_QUERY:
            begin
                qnum        = query_count;
                query_count = query_count + 1'b1;
                for (int i = 0; i < boxes_held; i++)
                begin
                    if (axis_hit(px, box_cx[i], box_w[i], tolerance) &&
                        axis_hit(py, box_cy[i], box_h[i], tolerance))
                        hits = {hits, i};
                end
                if (hits.size() == 0)
                begin
                    expect_result(make_result(ST_NONE, qnum, '0, '0, 1'b1));
                end
                else if (hits.size() == 1)
                begin
                    expect_result(make_result(ST_ATTACHED, qnum, BOX_INDEX_W'(hits[0]),
                                              MATCH_COUNT_W'(1), 1'b1));
                end
                else
                begin
                    foreach (hits[k])
                        expect_result(make_result(ST_AMBIG, qnum,
                                                  BOX_INDEX_W'(hits[k]),
                                                  MATCH_COUNT_W'(hits.size()),
                                                  k == hits.size() - 1));
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        attach_result_t want;
        attach_result_t got;
        if (!rst_n)
        begin
            boxes_held  = 0;
            query_count = '0;
            tolerance   = '0;
            mismatches  = 0;
            expected_q.delete();
            fail_count  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = make_result(rsp.status, rsp.query_number, rsp.box_index,
                                  rsp.match_count, rsp.last);
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"%0t unexpected result: status %0d qnum %0d",
                                  " box %0d count %0d last %0d"},
                                 $time, got.status, got.query_number, got.box_index,
                                 got.match_count, got.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status ||
                        got.query_number !== want.query_number ||
                        got.box_index !== want.box_index ||
                        got.match_count !== want.match_count || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t mismatch (exp/got): status %0d/%0d",
                                      " qnum %0d/%0d box %0d/%0d count %0d/%0d",
                                      " last %0d/%0d"},
                                     $time, want.status, got.status,
                                     want.query_number, got.query_number,
                                     want.box_index, got.box_index,
                                     want.match_count, got.match_count,
                                     want.last, got.last);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                tolerance = cfg.data;
            if (req.valid && req.ready)
                classify_command(req.func, req.center_x, req.center_y,
                                 req.size_x, req.size_y);
            fail_count  <= mismatches;
            results_due <= expected_q.size();
        end
    end

endmodule

@@ bench/tb_point_in_box_attach_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_box_attach_classifier_top: testbench of the attach classifier
// drives clear, load and query transactions with directed corner cases and
// random box clusters, sweeps the tolerance register and the idle patterns
// of both channel ends; a separate checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_point_in_box_attach_classifier_top;
    import pib_pkg::*;

    localparam int MAX_BOXES       = MAX_BOXES_DEF;
    localparam int COORD_BITS      = COORD_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 90;
    // a query walks the whole cell chain before its first result
    localparam int SETTLE_CYCLES   = MAX_BOXES + 8;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int TOL_MAX         = 32767;
    localparam int SIZE_MAX        = 65535;
    // func code with no meaning, the block drops it
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    pib_in_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    pib_cfg_if                           cfg_ch ();
    pib_out_if                           rsp_ch ();

    int fail_count;
    int results_due;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;
    int cur_tol;
    int phase_items;

    // shadow of the loaded boxes, only used to aim query points
    int aim_x [MAX_BOXES];
    int aim_y [MAX_BOXES];
    int aim_w [MAX_BOXES];
    int aim_h [MAX_BOXES];
    int aim_n;

    point_in_box_attach_classifier_top #(
        .MAX_BOXES (MAX_BOXES),
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .cfg  (cfg_ch),
        .rsp  (rsp_ch)
    );

    pib_attach_checker #(
        .MAX_BOXES(MAX_BOXES)
    ) attach_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .cfg        (cfg_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .results_due(results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random back-pressure per the current phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop if the block hangs or drops results
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int rand16();
        return $urandom_range(0, SIZE_MAX);
    endfunction

    // one request transaction; valid stays high into the next one when no
    // idle cycle is drawn, so it is never dropped and raised in one step
    task automatic issue(input logic [FUNC_W-1:0] f, input int x, input int y,
                         input int w, input int h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= f;
        req_ch.center_x <= COORD_BITS'(x);
        req_ch.center_y <= COORD_BITS'(y);
        req_ch.size_x   <= SIZE_W'(w);
        req_ch.size_y   <= SIZE_W'(h);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (f != FUNC_SPARE)
            phase_items++;
    endtask

    // occasional dropped func code between real transactions
    task automatic maybe_spare();
        if ($urandom_range(99) < 6)
            issue(FUNC_SPARE, rand16(), rand16(), rand16(), rand16());
    endtask

    // wait until every expected result is out, then let a trailing
    // clear or load finish inside the block
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic set_tolerance(input int v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= TOL_W'(v);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        cur_tol = v;
    endtask

    // mostly sizes near the cluster spread so boxes overlap, plus extremes
    function automatic int box_size(input int spread);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 0;
        else if (r < 16)
            return SIZE_MAX;
        else if (r < 24)
            return rand16();
        return $urandom_range(spread, 2 * spread + 64);
    endfunction

    // coordinate near a box along one axis: on the inclusive edge, one lsb
    // past it, or anywhere within a little beyond the grown box
    function automatic int aim_point(input int c, input int span);
        int reach;
        int r;
        reach = span / 2 + cur_tol + 4;
        r     = $urandom_range(99);
        if (r < 25)
            return $urandom_range(1) ? c + span / 2 + cur_tol + $urandom_range(1)
                                     : c - span / 2 - cur_tol - $urandom_range(1);
        return c + int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // one sequence: usually a clear, a cluster of loads, then queries
    // aimed at the loaded boxes; skipped clears let the table fill up
    task automatic run_episode();
        int n_boxes;
        int n_queries;
        int spread;
        int cx0;
        int cy0;
        int k;
        int r;
        int x;
        int y;
        int w;
        int h;
        if ($urandom_range(99) < 85)
        begin
            maybe_spare();
            issue(FUNC_CLEAR, rand16(), rand16(), rand16(), rand16());
            aim_n = 0;
        end
        r = $urandom_range(99);
        if (r < 12)
        begin
            // tight stack, long ambiguous runs and table-full results
            n_boxes = $urandom_range(30, 36);
            spread  = $urandom_range(0, 16);
        end
        else if (r < 22)
        begin
            n_boxes = 0;
            spread  = 0;
        end
        else
        begin
            n_boxes = $urandom_range(1, 8);
            spread  = $urandom_range(16, 600);
        end
        cx0 = rand16();
        cy0 = rand16();
        for (int i = 0; i < n_boxes; i++)
        begin
            x = cx0 + int'($urandom_range(0, 2 * spread)) - spread;
            y = cy0 + int'($urandom_range(0, 2 * spread)) - spread;
            w = box_size(spread);
            h = box_size(spread);
            maybe_spare();
            issue(FUNC_LOAD, x, y, w, h);
            if (aim_n < MAX_BOXES)
            begin
                aim_x[aim_n] = int'(COORD_BITS'(x));
                aim_y[aim_n] = int'(COORD_BITS'(y));
                aim_w[aim_n] = w;
                aim_h[aim_n] = h;
                aim_n++;
            end
        end
        n_queries = (n_boxes > 29) ? $urandom_range(2, 4) : $urandom_range(1, 8);
        for (int i = 0; i < n_queries; i++)
        begin
            if (aim_n != 0 && $urandom_range(99) < 75)
            begin
                k = $urandom_range(0, aim_n - 1);
                x = aim_point(aim_x[k], aim_w[k]);
                y = aim_point(aim_y[k], aim_h[k]);
            end
            else
            begin
                x = rand16();
                y = rand16();
            end
            maybe_spare();
            // size fields are don't-care on a query, keep them toggling
            issue(FUNC_QUERY, x, y, rand16(), rand16());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_CLEAR;
        req_ch.center_x = '0;
        req_ch.center_y = '0;
        req_ch.size_x   = '0;
        req_ch.size_y   = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        cur_tol         = 0;
        aim_n           = 0;
        phase_items     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling, zero tolerance
        set_tolerance(0);
        issue(FUNC_QUERY, 0, 0, 0, 0);                        // empty table, no box
        issue(FUNC_LOAD, 0, 0, 16, 16);                       // box 0
        issue(FUNC_QUERY, 8, -8, 0, 0);                       // corner on the edge, attached
        issue(FUNC_QUERY, 9, 0, 0, 0);                        // one lsb outside in x
        issue(FUNC_QUERY, 0, -9, 0, 0);                       // one lsb outside in y
        issue(FUNC_LOAD, -32768, 32767, SIZE_MAX, 0);         // box 1 at the extremes
        issue(FUNC_QUERY, -32768, 32767, SIZE_MAX, SIZE_MAX); // attached to box 1
        issue(FUNC_QUERY, 32767, 32767, 0, 0);                // full-range distance, none
        issue(FUNC_LOAD, 0, 0, 0, 0);                         // zero-size box 2
        issue(FUNC_QUERY, 0, 0, 0, 0);                        // ambiguous, boxes 0 and 2
        issue(FUNC_SPARE, -1, -1, SIZE_MAX, SIZE_MAX);        // dropped code
        issue(FUNC_LOAD, 4, 4, SIZE_MAX, SIZE_MAX);           // box 3, huge
        issue(FUNC_QUERY, 0, 0, 0, 0);                        // ambiguous, three boxes
        issue(FUNC_QUERY, -32768, -32768, 0, 0);              // just outside box 3
        issue(FUNC_QUERY, 32767, -32768, 0, 0);
        issue(FUNC_CLEAR, -1, -1, SIZE_MAX, SIZE_MAX);        // counter back to zero
        issue(FUNC_QUERY, 0, 0, 0, 0);
        issue(FUNC_LOAD, 32767, -32768, 1, 1);
        issue(FUNC_QUERY, 32767, -32768, 0, 0);

        // random part: one tolerance setting and one idle pattern per phase
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    set_tolerance(TOL_MAX);
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct     = 0;
                    set_tolerance($urandom_range(0, 64));
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 83;
                    set_tolerance($urandom_range(0, TOL_MAX));
                end
                default:
                begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                    set_tolerance(0);
                end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                run_episode();
        end

        drain();
        if (fail_count == 0 && results_due == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
